>>> src/sha256_hash_top_assert.svh
// Assertion macros for the SHA-256 hashing block.
// Included by sha256_hash_top; needs nothing else.
`ifndef SHA256_HASH_TOP_ASSERT_SVH
`define SHA256_HASH_TOP_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define SHA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha256_hash_top: same-cycle check failed");

// Next-cycle implication, checked only out of reset.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha256_hash_top: next-cycle check failed");

`endif

>>> src/sha_pkg.sv
// Shared types, constants and helper functions for the SHA-256 hashing block.
// Used by sha_sched, sha_round and sha256_hash_top; depends on nothing.
package sha_pkg;

    localparam int unsigned NUM_WORDS  = 8;
    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned BLOCK_BITS = 512;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] INIT_HASH [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Controls for the message window.
    typedef struct packed {
        logic       byte_en;
        logic [7:0] data;
        logic       word_en;
    } t_win_ctl;

    // Controls for the round unit.
    typedef struct packed {
        logic load;
        logic step;
        logic add;
        logic init;
        logic rotate;
    } t_rnd_ctl;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

>>> src/sha_sched.sv
// Message window and schedule expansion for SHA-256.
// Depends on sha_pkg for the control struct and rotate helper.
module sha_sched (
    input  logic              i_clk,
    input  sha_pkg::t_win_ctl i_ctl,
    output logic [31:0]       o_w
);

    logic [511:0] r_win;
    logic [31:0]  w0, w1, w9, w14, s0, s1, w_new;

    // Word t of the window sits at the top; bytes enter at the bottom.
    assign w0  = r_win[511:480];
    assign w1  = r_win[479:448];
    assign w9  = r_win[223:192];
    assign w14 = r_win[63:32];

    assign s0 = sha_pkg::ror32(w1, 7) ^ sha_pkg::ror32(w1, 18) ^ (w1 >> 3);
    assign s1 = sha_pkg::ror32(w14, 17) ^ sha_pkg::ror32(w14, 19) ^ (w14 >> 10);
    assign w_new = w0 + s0 + w9 + s1;

    always_ff @(posedge i_clk) begin
        if (i_ctl.byte_en) begin
            r_win <= {r_win[503:0], i_ctl.data};
        end else if (i_ctl.word_en) begin
            r_win <= {r_win[479:0], w_new};
        end
    end

    assign o_w = w0;

endmodule

>>> src/sha_round.sv
// SHA-256 round unit: working variables, hash words and the shared round adder.
// Depends on sha_pkg for constants, control struct and rotate helper.
module sha_round (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha_pkg::t_rnd_ctl i_ctl,
    input  logic [5:0]        i_rnd,
    input  logic [31:0]       i_w,
    output logic [31:0]       o_digest
);

    logic [31:0] r_hash [0:7];
    logic [31:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [31:0] big_s0, big_s1, ch, maj, t1, t2;

    assign big_s1 = sha_pkg::ror32(r_e, 6) ^ sha_pkg::ror32(r_e, 11) ^ sha_pkg::ror32(r_e, 25);
    assign ch     = (r_e & r_f) ^ (~r_e & r_g);
    assign t1     = r_h + big_s1 + ch + sha_pkg::ROUND_K[i_rnd] + i_w;
    assign big_s0 = sha_pkg::ror32(r_a, 2) ^ sha_pkg::ror32(r_a, 13) ^ sha_pkg::ror32(r_a, 22);
    assign maj    = (r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c);
    assign t2     = big_s0 + maj;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= r_hash[0]; r_b <= r_hash[1]; r_c <= r_hash[2]; r_d <= r_hash[3];
            r_e <= r_hash[4]; r_f <= r_hash[5]; r_g <= r_hash[6]; r_h <= r_hash[7];
        end else if (i_ctl.step) begin
            r_h <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
            r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= sha_pkg::INIT_HASH[i];
            end
        end else if (i_ctl.add) begin
            r_hash[0] <= r_hash[0] + r_a; r_hash[1] <= r_hash[1] + r_b;
            r_hash[2] <= r_hash[2] + r_c; r_hash[3] <= r_hash[3] + r_d;
            r_hash[4] <= r_hash[4] + r_e; r_hash[5] <= r_hash[5] + r_f;
            r_hash[6] <= r_hash[6] + r_g; r_hash[7] <= r_hash[7] + r_h;
        end else if (i_ctl.rotate) begin
            // Word 0 leaves at the top; the ring brings the next word up.
            for (int i = 0; i < 7; i++) begin
                r_hash[i] <= r_hash[i + 1];
            end
            r_hash[7] <= r_hash[0];
        end
    end

    assign o_digest = r_hash[0];

endmodule

>>> src/sha256_hash_top.sv
// SHA-256 hashing block: top level with the sequencer.
// Depends on sha_pkg, sha_sched, sha_round and sha256_hash_top_assert.svh.
// Usage:
//   The slave channel takes one transfer per message byte (tuser = 0, byte in
//   tdata) or a finish transfer (tuser = 1, tdata ignored). The master channel
//   returns the digest as eight transfers, word 0 (most significant) first;
//   tdata carries the word and its index, tlast marks word 7.
// Operation:
//   A data byte is taken whenever the block is idle. The 64th byte of a
//   block starts the compression: the single shared round unit runs the
//   rounds (one round per cycle), then the result is added into the hash
//   words; no byte is taken meanwhile. A finish pads one byte per cycle up
//   to the end of the block, compresses once or twice (twice when 56 or more
//   bytes were buffered), then presents the eight digest words, one per
//   cycle while the receiver takes them.
// Stall and reset:
//   s_axis_tready is high only while the block waits for input. A stalled
//   receiver holds the current word; no input is taken until the last word
//   leaves and the hash restarts. Synchronous active-low reset returns to the
//   idle state with the initial hash values, an empty buffer and zero length.
`include "sha256_hash_top_assert.svh"

module sha256_hash_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_axis_tlast    // last_word
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_ADD   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [5:0]  r_rnd, n_rnd;
    logic [2:0]  r_idx, n_idx;
    logic [63:0] r_bits, n_bits;
    logic [63:0] r_total, n_total;
    logic        r_fin, n_fin;
    logic        r_first, n_first;
    logic        r_len_ok, n_len_ok;

    sha_pkg::t_win_ctl win_ctl;
    sha_pkg::t_rnd_ctl rnd_ctl;
    logic [31:0] sched_w;
    logic [31:0] digest;
    logic        in_xfer, out_xfer, len_byte;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    // Length bytes fill the last eight positions of the final block.
    assign len_byte = !r_first && r_len_ok && (&r_fill[5:3]);

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_rnd    = r_rnd;
        n_idx    = r_idx;
        n_bits   = r_bits;
        n_total  = r_total;
        n_fin    = r_fin;
        n_first  = r_first;
        n_len_ok = r_len_ok;
        win_ctl  = '0;
        rnd_ctl  = '0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;

        case (r_state)
            S_IDLE: begin
                // Ready is high throughout this state, so valid alone marks a transfer.
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (s_axis_tuser[0] == sha_pkg::KIND_FINISH) begin
                        n_total = r_bits + {55'd0, r_fill, 3'd0};
                        n_fin   = 1'b1;
                        n_first = 1'b1;
                        n_state = S_PAD;
                    end else begin
                        win_ctl.byte_en = 1'b1;
                        win_ctl.data    = s_axis_tdata;
                        n_fill = r_fill + 6'd1;
                        if (&r_fill) begin
                            rnd_ctl.load = 1'b1;
                            n_rnd   = '0;
                            n_state = S_ROUND;
                        end
                    end
                end
            end
            S_PAD: begin
                win_ctl.byte_en = 1'b1;
                if (r_first) begin
                    win_ctl.data = sha_pkg::PAD_MARK;
                    n_len_ok = !(&r_fill[5:3]);
                end else if (len_byte) begin
                    win_ctl.data = r_total[63:56];
                    n_total = {r_total[55:0], 8'd0};
                end else begin
                    win_ctl.data = 8'd0;
                end
                n_first = 1'b0;
                n_fill  = r_fill + 6'd1;
                if (&r_fill) begin
                    rnd_ctl.load = 1'b1;
                    n_rnd   = '0;
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                rnd_ctl.step    = 1'b1;
                win_ctl.word_en = 1'b1;
                n_rnd = r_rnd + 6'd1;
                if (&r_rnd) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                rnd_ctl.add = 1'b1;
                if (!r_fin) begin
                    n_bits  = r_bits + 64'(sha_pkg::BLOCK_BITS);
                    n_state = S_IDLE;
                end else if (r_len_ok) begin
                    n_idx   = '0;
                    n_state = S_OUT;
                end else begin
                    // Padding spilled over: one more block carries the length.
                    n_len_ok = 1'b1;
                    n_state  = S_PAD;
                end
            end
            S_OUT: begin
                // Valid is high throughout this state, so ready alone marks a transfer.
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    rnd_ctl.rotate = 1'b1;
                    n_idx = r_idx + 3'd1;
                    if (&r_idx) begin
                        rnd_ctl.init = 1'b1;
                        n_bits  = '0;
                        n_fill  = '0;
                        n_fin   = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_rnd    <= '0;
            r_idx    <= '0;
            r_bits   <= '0;
            r_total  <= '0;
            r_fin    <= 1'b0;
            r_first  <= 1'b0;
            r_len_ok <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_rnd    <= n_rnd;
            r_idx    <= n_idx;
            r_bits   <= n_bits;
            r_total  <= n_total;
            r_fin    <= n_fin;
            r_first  <= n_first;
            r_len_ok <= n_len_ok;
        end
    end

    sha_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (win_ctl),
        .o_w   (sched_w)
    );

    sha_round u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (rnd_ctl),
        .i_rnd    (r_rnd),
        .i_w      (sched_w),
        .o_digest (digest)
    );

    assign m_axis_tdata = {5'd0, r_idx, digest};
    assign m_axis_tlast = &r_idx;

    // Input and output sides are never open in the same cycle.
    `SHA_ASSERT_SAME(a_no_overlap, i_clk, i_rst_n, s_axis_tready, !m_axis_tvalid)
    // A finish transfer closes the input until the digest is out.
    `SHA_ASSERT_NEXT(a_finish_blocks, i_clk, i_rst_n,
        in_xfer && (s_axis_tuser[0] == sha_pkg::KIND_FINISH), !s_axis_tready)
    // The last digest transfer hands control back to the input side.
    `SHA_ASSERT_NEXT(a_last_reopens, i_clk, i_rst_n,
        out_xfer && m_axis_tlast, s_axis_tready && !m_axis_tvalid)

endmodule

>>> sim/tb.sv
// Self-checking testbench for sha256_hash_top: directed messages, then random
// messages with boundary lengths, with a SHA-256 predictor built in.
// Depends on sha_pkg and sha256_hash_top.
`timescale 1ns / 1ps

module tb;

    localparam logic DATA = sha_pkg::KIND_DATA;
    localparam logic FIN  = sha_pkg::KIND_FINISH;

    localparam int RANDOM_ITEMS = 400;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 1000000;

    // Message lengths around the padding and block edges.
    localparam int TIGHT_LENS [12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // One directed transfer. A finish row with known set carries the digest
    // that is expected, typed in; every other finish is checked against the
    // predictor.
    typedef struct packed {
        logic         kind;
        logic [7:0]   data;
        logic         known;
        logic [255:0] digest;
    } t_msg_row;

    localparam int NUM_ROWS = 16;
    localparam t_msg_row MSG_ROWS [NUM_ROWS] = '{
        '{FIN,  8'h00, 1'b1, EMPTY_DIGEST},  // empty message straight after reset
        '{FIN,  8'hff, 1'b1, EMPTY_DIGEST},  // empty again, tdata of a finish ignored
        '{DATA, 8'h61, 1'b0, 256'd0},
        '{DATA, 8'h62, 1'b0, 256'd0},
        '{DATA, 8'h63, 1'b0, 256'd0},
        '{FIN,  8'h00, 1'b1, ABC_DIGEST},
        '{DATA, 8'h00, 1'b0, 256'd0},        // extreme byte values and bit patterns
        '{DATA, 8'hff, 1'b0, 256'd0},
        '{DATA, 8'h01, 1'b0, 256'd0},
        '{DATA, 8'h80, 1'b0, 256'd0},
        '{DATA, 8'h7f, 1'b0, 256'd0},
        '{DATA, 8'ha5, 1'b0, 256'd0},
        '{DATA, 8'h5a, 1'b0, 256'd0},
        '{FIN,  8'h5a, 1'b0, 256'd0},
        '{DATA, 8'hff, 1'b0, 256'd0},
        '{FIN,  8'h00, 1'b0, 256'd0}
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic [0:0]  s_axis_tuser;   // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [31:0] digest_word, [34:32] word_index, rest zero
    logic        m_axis_tlast;   // last_word

    // Predictor state: running hash, bits in finished blocks, and the block
    // being filled.
    logic [31:0] hash_state [8];
    logic [63:0] bits_hashed;
    logic [7:0]  block_bytes [64];
    logic [5:0]  block_fill;

    t_digest_word digest_due [$];
    t_digest_word due_word;
    int          fail_count = 0;
    int          items_sent = 0;
    int          cycles = 0;
    bit          steady = 1'b0;

    sha256_hash_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Either side skips a cycle about 22 times in a hundred, except during
    // the steady stretch in the middle of the random part.
    function automatic bit take_gap();
        return !steady && ($urandom_range(99) < 22);
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        logic [63:0] dbl;
        dbl = {v, v} >> n;
        return dbl[31:0];
    endfunction

    task automatic restart_hash();
        for (int k = 0; k < 8; k++) hash_state[k] = START_HASH[k];
        bits_hashed = 64'd0;
        block_fill  = 6'd0;
    endtask

    // One full compression of block_bytes into hash_state.
    task automatic mix_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] s0, s1, t1, t2;
        for (int t = 0; t < 16; t++) begin
            w[t] = {block_bytes[4*t], block_bytes[4*t+1],
                    block_bytes[4*t+2], block_bytes[4*t+3]};
        end
        for (int t = 16; t < 64; t++) begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int t = 0; t < 64; t++) begin
            s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
            t1 = h + s1 + ((e & f) ^ (~e & g)) + ROUND_CONST[t] + w[t];
            s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
            t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    // Advances the predictor by one accepted transfer. A finish pads the
    // message, which spills into a second block when 56 or more bytes are
    // buffered, and returns the digest with H0 in the top bits.
    task automatic absorb_item(input logic kind, input logic [7:0] data,
                               output logic done, output logic [255:0] digest);
        logic [63:0] total;
        int          pos;
        done   = 1'b0;
        digest = '0;
        if (kind == DATA) begin
            block_bytes[block_fill] = data;
            block_fill = block_fill + 6'd1;
            if (block_fill == 6'd0) begin
                mix_block();
                bits_hashed += 64'd512;
            end
        end else begin
            total = bits_hashed + {55'd0, block_fill, 3'd0};
            pos = int'(block_fill);
            block_bytes[pos] = 8'h80;
            pos++;
            if (pos > 56) begin
                while (pos < 64) begin
                    block_bytes[pos] = 8'h00;
                    pos++;
                end
                mix_block();
                pos = 0;
            end
            while (pos < 56) begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            for (int k = 0; k < 8; k++) block_bytes[56+k] = total[63-8*k -: 8];
            mix_block();
            for (int k = 0; k < 8; k++) digest[255-32*k -: 32] = hash_state[k];
            done = 1'b1;
            restart_hash();
        end
    endtask

    // Presents one transfer on the slave side, with random idle cycles in
    // front, and waits until it is taken. The predictor runs at acceptance.
    task automatic send_item(input logic kind, input logic [7:0] data,
                             input logic known, input logic [255:0] typed_digest);
        logic         done;
        logic [255:0] digest;
        t_digest_word word_due;
        steady = (items_sent >= NUM_ROWS + 150) && (items_sent < NUM_ROWS + 260);
        while (take_gap()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        absorb_item(kind, data, done, digest);
        if (done) begin
            if (known) digest = typed_digest;
            for (int k = 0; k < 8; k++) begin
                word_due = '{digest[255-32*k -: 32], 3'(k), k == 7};
                digest_due = {digest_due, word_due};
            end
        end
    endtask

    // Master side: random backpressure, and every accepted digest transfer
    // is compared with the oldest word still due.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !take_gap();
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (digest_due.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("unexpected digest transfer: tdata=%h tlast=%b",
                             m_axis_tdata, m_axis_tlast);
                end
            end else begin
                due_word = digest_due.pop_front();
                if (m_axis_tdata !== {5'd0, due_word.index, due_word.word} ||
                    m_axis_tlast !== due_word.last) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("word %0d: expected %h last=%b, got tdata=%h tlast=%b",
                                 due_word.index, due_word.word, due_word.last,
                                 m_axis_tdata, m_axis_tlast);
                    end
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int msg_len;
        int last_item;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tuser  <= DATA;
        restart_hash();
        for (int k = 0; k < 64; k++) block_bytes[k] = 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            send_item(MSG_ROWS[r].kind, MSG_ROWS[r].data, MSG_ROWS[r].known,
                      MSG_ROWS[r].digest);
        end

        // Random messages: a third of them take a length on a padding or
        // block edge, including the case that needs an extra padding block.
        last_item = items_sent + RANDOM_ITEMS;
        while (items_sent < last_item) begin
            if ($urandom_range(2) == 0) begin
                msg_len = TIGHT_LENS[$urandom_range(11)];
            end else begin
                msg_len = $urandom_range(70);
            end
            for (int n = 0; n < msg_len; n++) begin
                send_item(DATA, 8'($urandom), 1'b0, 256'd0);
            end
            send_item(FIN, 8'($urandom), 1'b0, 256'd0);
        end
        s_axis_tvalid <= 1'b0;

        while (digest_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
